// ----- src/tat_pkg.sv -----
// ----------------------------------------------------------------------------
// tat_pkg
// Types and constants for the two-anchor trilateration unit.
// ----------------------------------------------------------------------------
package tat_pkg;

   localparam int MAX_TAGS_DEF = 16;
   localparam int FRAC_BITS    = 16;
   localparam int POS_W        = 24;
   localparam int DIST_W       = 23;
   localparam int ID_W         = 8;
   localparam int TAG_W        = 4;
   localparam int STATUS_W     = 3;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_COUNT    = 8;

   localparam logic [ID_W-1:0] ID_A = 8'd101;
   localparam logic [ID_W-1:0] ID_B = 8'd102;
   localparam logic [ID_W-1:0] ID_C = 8'd103;
   localparam logic [ID_W-1:0] ID_D = 8'd104;

   localparam logic [STATUS_W-1:0] ST_EDGE    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_MATCH   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_HELD    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOHIST  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_INVALID = 3'd4;

   // 0.1 m in LSBs, rounded
   localparam int THR = ((1 << FRAC_BITS) + 5) / 10;

   typedef struct packed {
      logic [TAG_W-1:0]  tag_index;
      logic [ID_W-1:0]   first_anchor_id;
      logic [DIST_W-1:0] first_distance;
      logic [ID_W-1:0]   second_anchor_id;
      logic [DIST_W-1:0] second_distance;
   } req_type;

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic [STATUS_W-1:0]     status;
      logic                    no_real_intersection;
   } rsp_type;

endpackage

// ----- src/two_anchor_trilateration_unit.sv -----
// ----------------------------------------------------------------------------
// two_anchor_trilateration_unit
// Intersects two anchor range circles and picks a tag position using
// anchor geometry or the tag's last position.
// ----------------------------------------------------------------------------
// An invalid pair is answered straight from the selection state; a valid
// pair runs the whole sequence, a shorter one when the circles do not meet.
// One transaction at a time: a new request is taken only once the last response
// has gone. Work runs on the shared bit-serial divider (five uses) and square root (up to two).
// Reset: clears the control state, the anchor registers and the history
// valid bits; history positions are undefined until written.
module two_anchor_trilateration_unit #(
   parameter int MAX_TAGS = tat_pkg::MAX_TAGS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  tat_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output tat_pkg::rsp_type              rsp_data,
   input  logic                          csr_write_enable,
   input  logic [tat_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tat_pkg::POS_W-1:0]     csr_data
);
   import tat_pkg::*;

   localparam int IDX_W = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1;
   localparam int DVW   = 54;
   localparam int SQW   = 56;

   localparam logic [4:0] S_IDLE = 5'd0,  S_SEL = 5'd1,  S_MDX = 5'd2,  S_MDY = 5'd3,
                          S_MR1  = 5'd4,  S_MR2 = 5'd5,  S_NUM = 5'd6,  S_SQRT = 5'd7,
                          S_DNUM = 5'd8,  S_DIV = 5'd9,  S_MAA = 5'd10, S_H2 = 5'd11,
                          S_MAX  = 5'd12, S_MAY = 5'd13, S_MHY = 5'd14, S_MHX = 5'd15,
                          S_QPR  = 5'd16, S_PTS = 5'd17, S_PICK = 5'd18, S_OUT = 5'd19;

   localparam logic [2:0] DV_A = 3'd0, DV_TX = 3'd1, DV_TY = 3'd2, DV_OX = 3'd3, DV_OY = 3'd4;

   logic [4:0] state_ff, state_in;
   logic signed [POS_W-1:0] cfg_ff [CSR_COUNT];
   req_type req_ff;
   rsp_type rsp_ff, rsp_in;

   logic [ID_W-1:0] id1_ff, id2_ff;
   logic [DIST_W-1:0] r1_ff, r2_ff;
   logic signed [POS_W-1:0] x1_ff, y1_ff;
   logic signed [POS_W:0] dx_ff, dy_ff;
   logic signed [63:0] prod_ff;
   logic [49:0] d2_ff;
   logic [45:0] r1sq_ff;
   logic signed [51:0] num_ff;
   logic [25:0] dd_ff;
   logic signed [27:0] a_ff;
   logic [23:0] h_ff;
   logic flag_ff;
   logic signed [28:0] tx_ff, ty_ff;
   logic signed [24:0] ox_ff, oy_ff;
   logic signed [POS_W-1:0] p1x_ff, p1y_ff, p2x_ff, p2y_ff;
   logic sq_sel_ff, dv_neg_ff;
   logic [2:0] dv_sel_ff;
   logic [5:0] cnt_ff;
   logic [SQW-1:0] sq_val_ff;
   logic [28:0] sq_rem_ff;
   logic [27:0] sq_root_ff;
   logic [DVW-1:0] dv_dvd_ff;
   logic [27:0] dv_rem_ff;
   logic [26:0] dv_dsr_ff;
   logic [MAX_TAGS-1:0] hv_ff;
   logic signed [POS_W-1:0] hx_ff [MAX_TAGS];
   logic signed [POS_W-1:0] hy_ff [MAX_TAGS];
   logic [IDX_W-1:0] idx;

   logic signed [31:0] mul_a, mul_b;
   logic [30:0] sq_sh, sq_trial;
   logic [28:0] sq_rem_in;
   logic [27:0] sq_root_in;
   logic [28:0] dv_sh;
   logic dv_bit;
   logic [27:0] dv_rem_in;
   logic [DVW:0] dv_q;
   logic signed [DVW:0] dv_qs;
   logic signed [27:0] a_sat;
   logic signed [53:0] h2;
   logic signed [29:0] e1x, e1y, e2x, e2y;
   logic signed [POS_W:0] d1s, d2s;
   logic [POS_W:0] d1, d2;
   logic s_k0, s_k1, s_have2;
   logic [ID_W-1:0] s_id1, s_id2;
   logic [DIST_W-1:0] s_r1, s_r2;
   logic signed [POS_W-1:0] s_x1, s_y1, s_x2, s_y2;
   logic edge_pair, take1, close;

   function automatic logic signed [POS_W-1:0] sat24(input logic signed [29:0] v);
      if (v > 30'sd8388607) return 24'sh7FFFFF;
      if (v < -30'sd8388608) return 24'sh800000;
      return v[POS_W-1:0];
   endfunction

   function automatic logic [1:0] anc(input logic [ID_W-1:0] id);
      logic [ID_W-1:0] t;
      t = id - ID_A;
      return t[1:0];
   endfunction

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_data  = rsp_ff;

   always_comb begin
      idx = '0;
      for (int k = 0; k < 16; k++) begin
         if (req_ff.tag_index == TAG_W'(k)) idx = IDX_W'(k % MAX_TAGS);
      end
   end

   // anchor slot selection
   always_comb begin
      s_k0 = (req_ff.first_anchor_id >= ID_A) && (req_ff.first_anchor_id <= ID_D);
      s_k1 = (req_ff.second_anchor_id >= ID_A) && (req_ff.second_anchor_id <= ID_D);
      s_id1 = '0; s_id2 = '0; s_r1 = '0; s_r2 = '0; s_have2 = 1'b0;
      if (s_k0) begin
         s_id1 = req_ff.first_anchor_id;
         s_r1  = req_ff.first_distance;
      end
      if (s_k1) begin
         if (s_r1 == '0) begin
            s_id1 = req_ff.second_anchor_id;
            s_r1  = req_ff.second_distance;
         end else begin
            s_id2 = req_ff.second_anchor_id;
            s_r2  = req_ff.second_distance;
            s_have2 = 1'b1;
         end
      end
      s_x1 = cfg_ff[{anc(s_id1), 1'b0}];
      s_y1 = cfg_ff[{anc(s_id1), 1'b1}];
      s_x2 = cfg_ff[{anc(s_id2), 1'b0}];
      s_y2 = cfg_ff[{anc(s_id2), 1'b1}];
   end

   always_comb begin
      unique case (state_ff)
         S_MDX:   begin mul_a = 32'(dx_ff); mul_b = 32'(dx_ff); end
         S_MDY:   begin mul_a = 32'(dy_ff); mul_b = 32'(dy_ff); end
         S_MR1:   begin mul_a = 32'(r1_ff); mul_b = 32'(r1_ff); end
         S_MR2:   begin mul_a = 32'(r2_ff); mul_b = 32'(r2_ff); end
         S_MAA:   begin mul_a = 32'(a_ff);  mul_b = 32'(a_ff);  end
         S_MAX:   begin mul_a = 32'(a_ff);  mul_b = 32'(dx_ff); end
         S_MAY:   begin mul_a = 32'(a_ff);  mul_b = 32'(dy_ff); end
         S_MHY:   begin mul_a = 32'(h_ff);  mul_b = 32'(dy_ff); end
         S_MHX:   begin mul_a = 32'(h_ff);  mul_b = 32'(dx_ff); end
         default: begin mul_a = '0;         mul_b = '0;         end
      endcase
   end

   always_comb begin
      sq_sh    = {sq_rem_ff, sq_val_ff[SQW-1 -: 2]};
      sq_trial = {1'b0, sq_root_ff, 2'b01};
      if (sq_sh >= sq_trial) begin
         sq_rem_in  = 29'(sq_sh - sq_trial);
         sq_root_in = {sq_root_ff[26:0], 1'b1};
      end else begin
         sq_rem_in  = sq_sh[28:0];
         sq_root_in = {sq_root_ff[26:0], 1'b0};
      end
      dv_sh  = {dv_rem_ff, dv_dvd_ff[DVW-1]};
      dv_bit = (dv_sh >= {2'b00, dv_dsr_ff});
      dv_rem_in = dv_bit ? 28'(dv_sh - {2'b00, dv_dsr_ff}) : dv_sh[27:0];
      dv_q   = {1'b0, dv_dvd_ff[DVW-2:0], dv_bit};
      dv_qs  = dv_neg_ff ? -$signed(dv_q) : $signed(dv_q);
      if (dv_qs > (DVW+1)'(64'sd67108864))       a_sat = 28'sd67108864;
      else if (dv_qs < -(DVW+1)'(64'sd67108864)) a_sat = -28'sd67108864;
      else                                        a_sat = dv_qs[27:0];
      h2 = $signed({8'd0, r1sq_ff}) - 54'(prod_ff);
      e1x = 30'(tx_ff) - 30'(ox_ff);
      e1y = 30'(ty_ff) + 30'(oy_ff);
      e2x = 30'(tx_ff) + 30'(ox_ff);
      e2y = 30'(ty_ff) - 30'(oy_ff);
      d1s = 25'(hx_ff[idx]) - 25'(p1x_ff);
      d2s = 25'(hx_ff[idx]) - 25'(p2x_ff);
      d1  = d1s[POS_W] ? 25'(-d1s) : 25'(d1s);
      d2  = d2s[POS_W] ? 25'(-d2s) : 25'(d2s);
      edge_pair = ((id1_ff == ID_A) && (id2_ff == ID_B)) || ((id1_ff == ID_B) && (id2_ff == ID_A))
               || ((id1_ff == ID_C) && (id2_ff == ID_D)) || ((id1_ff == ID_D) && (id2_ff == ID_C));
      take1 = (id1_ff <= ID_B) ? (p1y_ff > p2y_ff) : (p1y_ff < p2y_ff);
      close = (h_ff != '0) && ((d1 < 25'(THR)) || (d2 < 25'(THR)));
   end

   always_comb begin
      state_in = state_ff;
      rsp_in   = rsp_ff;
      unique case (state_ff)
         S_IDLE: if (req_valid) state_in = S_SEL;
         S_SEL: begin
            if (!s_have2 || ((s_x2 == s_x1) && (s_y2 == s_y1))) begin
               rsp_in   = '{pos_x: '0, pos_y: '0, status: ST_INVALID, no_real_intersection: 1'b0};
               state_in = S_OUT;
            end else begin
               state_in = S_MDX;
            end
         end
         S_MDX: state_in = S_MDY;
         S_MDY: state_in = S_MR1;
         S_MR1: state_in = S_MR2;
         S_MR2: state_in = S_NUM;
         S_NUM: state_in = S_SQRT;
         S_SQRT: if (cnt_ff == 6'(SQW/2 - 1)) state_in = sq_sel_ff ? S_MAX : S_DNUM;
         S_DNUM: state_in = S_DIV;
         S_DIV: begin
            if (cnt_ff == 6'(DVW - 1)) begin
               unique case (dv_sel_ff)
                  DV_A:    state_in = S_MAA;
                  DV_TX:   state_in = S_MAY;
                  DV_TY:   state_in = S_MHY;
                  DV_OX:   state_in = S_MHX;
                  default: state_in = S_PTS;
               endcase
            end
         end
         S_MAA: state_in = S_H2;
         S_H2:  state_in = h2[53] ? S_MAX : S_SQRT;
         S_MAX, S_MAY, S_MHY, S_MHX: state_in = S_QPR;
         S_QPR: state_in = S_DIV;
         S_PTS: state_in = S_PICK;
         S_PICK: begin
            rsp_in.no_real_intersection = flag_ff;
            if (edge_pair) begin
               rsp_in.pos_x  = take1 ? p1x_ff : p2x_ff;
               rsp_in.pos_y  = take1 ? p1y_ff : p2y_ff;
               rsp_in.status = ST_EDGE;
            end else if (hv_ff[idx]) begin
               if (close) begin
                  rsp_in.pos_x  = (d1 < d2) ? p1x_ff : p2x_ff;
                  rsp_in.pos_y  = (d1 < d2) ? p1y_ff : p2y_ff;
                  rsp_in.status = ST_MATCH;
               end else begin
                  rsp_in.pos_x  = hx_ff[idx];
                  rsp_in.pos_y  = hy_ff[idx];
                  rsp_in.status = ST_HELD;
               end
            end else begin
               rsp_in.pos_x  = p2x_ff;
               rsp_in.pos_y  = p2y_ff;
               rsp_in.status = ST_NOHIST;
            end
            state_in = S_OUT;
         end
         S_OUT: if (!rsp_stall) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         hv_ff    <= '0;
         for (int k = 0; k < CSR_COUNT; k++) cfg_ff[k] <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) cfg_ff[csr_index] <= csr_data;
         if ((state_ff == S_PICK) && edge_pair) hv_ff[idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      prod_ff <= mul_a * mul_b;
      if (state_ff == S_IDLE) req_ff <= req_data;
      unique case (state_ff)
         S_SEL: begin
            id1_ff <= s_id1; id2_ff <= s_id2; r1_ff <= s_r1; r2_ff <= s_r2;
            x1_ff <= s_x1; y1_ff <= s_y1;
            dx_ff <= 25'(s_x2) - 25'(s_x1);
            dy_ff <= 25'(s_y2) - 25'(s_y1);
            flag_ff <= 1'b0;
         end
         S_MDY: d2_ff <= 50'(prod_ff);
         S_MR1: d2_ff <= d2_ff + 50'(prod_ff);
         S_MR2: r1sq_ff <= 46'(prod_ff);
         S_NUM: begin
            num_ff <= $signed({6'd0, r1sq_ff}) - 52'(prod_ff) + $signed({2'd0, d2_ff});
            sq_val_ff <= SQW'(d2_ff); sq_rem_ff <= '0; sq_root_ff <= '0;
            sq_sel_ff <= 1'b0; cnt_ff <= '0;
         end
         S_SQRT: begin
            sq_val_ff <= {sq_val_ff[SQW-3:0], 2'b00};
            sq_rem_ff <= sq_rem_in; sq_root_ff <= sq_root_in;
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'(SQW/2 - 1)) begin
               if (sq_sel_ff) h_ff <= sq_root_in[23:0];
               else dd_ff <= sq_root_in[25:0];
            end
         end
         S_DNUM: begin
            dv_neg_ff <= num_ff[51];
            dv_dvd_ff <= DVW'(num_ff[51] ? -num_ff : num_ff);
            dv_dsr_ff <= {dd_ff, 1'b0};
            dv_rem_ff <= '0; dv_sel_ff <= DV_A; cnt_ff <= '0;
         end
         S_DIV: begin
            dv_dvd_ff <= {dv_dvd_ff[DVW-2:0], dv_bit};
            dv_rem_ff <= dv_rem_in;
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'(DVW - 1)) begin
               unique case (dv_sel_ff)
                  DV_A:    a_ff  <= a_sat;
                  DV_TX:   tx_ff <= 29'(x1_ff) + dv_qs[28:0];
                  DV_TY:   ty_ff <= 29'(y1_ff) + dv_qs[28:0];
                  DV_OX:   ox_ff <= dv_qs[24:0];
                  default: oy_ff <= dv_qs[24:0];
               endcase
            end
         end
         S_H2: begin
            if (h2[53]) begin
               h_ff <= '0; flag_ff <= 1'b1;
            end else begin
               sq_val_ff <= SQW'(h2); sq_rem_ff <= '0; sq_root_ff <= '0;
               sq_sel_ff <= 1'b1; cnt_ff <= '0;
            end
         end
         S_MAX: dv_sel_ff <= DV_TX;
         S_MAY: dv_sel_ff <= DV_TY;
         S_MHY: dv_sel_ff <= DV_OX;
         S_MHX: dv_sel_ff <= DV_OY;
         S_QPR: begin
            dv_neg_ff <= prod_ff[63];
            dv_dvd_ff <= DVW'(prod_ff[63] ? -prod_ff : prod_ff);
            dv_dsr_ff <= {1'b0, dd_ff};
            dv_rem_ff <= '0; cnt_ff <= '0;
         end
         S_PTS: begin
            p1x_ff <= sat24(e1x); p1y_ff <= sat24(e1y);
            p2x_ff <= sat24(e2x); p2y_ff <= sat24(e2y);
         end
         S_PICK: begin
            if (edge_pair || (hv_ff[idx] && close)) begin
               hx_ff[idx] <= rsp_in.pos_x;
               hy_ff[idx] <= rsp_in.pos_y;
            end
         end
         default: ;
      endcase
   end

   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall) else $error("accepted while busy");
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_INVALID) |->
      (rsp_data.pos_x == '0 && rsp_data.pos_y == '0 && !rsp_data.no_real_intersection))
      else $error("invalid pair result not cleared");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");
   a_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && !req_stall)) else $error("result shown while idle");

endmodule
